[design/cpx_pkg.sv]
package cpx_pkg;

    // Default data format: signed Q16.16.
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Width of the mode field of an operand word.
    localparam int MODE_WIDTH = 3;

    // Operation codes. Codes 6 and 7 have no meaning and return zero.
    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_ADD      = 3'd0,
        MODE_SUB      = 3'd1,
        MODE_SCALE_RE = 3'd2,
        MODE_SCALE_IM = 3'd3,
        MODE_MUL      = 3'd4,
        MODE_MAG      = 3'd5
    } mode_t;

endpackage

[design/cpx_in_if.sv]
interface cpx_in_if
    import cpx_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [MODE_WIDTH-1:0]        mode;
    logic signed [DATA_WIDTH-1:0] a_real;
    logic signed [DATA_WIDTH-1:0] a_imag;
    logic signed [DATA_WIDTH-1:0] b_real;
    logic signed [DATA_WIDTH-1:0] b_imag;
    logic signed [DATA_WIDTH-1:0] scale_factor;

    modport source (
        output valid, mode, a_real, a_imag, b_real, b_imag, scale_factor,
        input  ready
    );

    modport sink (
        input  valid, mode, a_real, a_imag, b_real, b_imag, scale_factor,
        output ready
    );
endinterface

[design/cpx_out_if.sv]
interface cpx_out_if
    import cpx_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res_real;
    logic signed [DATA_WIDTH-1:0] res_imag;
    logic                         overflow;

    modport source (
        output valid, res_real, res_imag, overflow,
        input  ready
    );

    modport sink (
        input  valid, res_real, res_imag, overflow,
        output ready
    );
endinterface

[design/cpx_isqrt.sv]
// Pipelined integer square root: one root bit per stage, most significant
// bit first. The root of a 2*ROOT_WIDTH-bit radicand leaves the last stage;
// the stages advance only while en is high.
module cpx_isqrt
    import cpx_pkg::*;
#(
    parameter int ROOT_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [2*ROOT_WIDTH-1:0] radicand,
    output logic [ROOT_WIDTH-1:0]   root
);
    localparam int RAD_WIDTH = 2 * ROOT_WIDTH;

    // Partial remainder, partial root and unused radicand bits of each stage.
    logic [ROOT_WIDTH:0]   rem_reg  [ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0] root_reg [ROOT_WIDTH];
    logic [RAD_WIDTH-1:0]  rad_reg  [ROOT_WIDTH];

    for (genvar k = 0; k < ROOT_WIDTH; k++)
    begin : g_step
        logic [ROOT_WIDTH:0]   rem_in;
        logic [ROOT_WIDTH-1:0] root_in;
        logic [RAD_WIDTH-1:0]  rad_in;
        logic [ROOT_WIDTH+1:0] rem_sh;
        logic [ROOT_WIDTH+1:0] trial;
        logic [ROOT_WIDTH+1:0] diff;
        logic                  ge;

        // The first stage starts from an empty remainder and root.
        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        // Bring down the next two radicand bits and try a one in this root bit.
        assign rem_sh = {rem_in[ROOT_WIDTH-1:0], rad_in[RAD_WIDTH-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);
        assign diff   = rem_sh - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[ROOT_WIDTH:0] : rem_sh[ROOT_WIDTH:0];
                root_reg[k] <= {root_in[ROOT_WIDTH-2:0], ge};
                rad_reg[k]  <= rad_in << 2;
            end
        end
    end

    assign root = root_reg[ROOT_WIDTH-1];

endmodule

[design/complex_alu.sv]
// Channel   Dir  Word fields
// --------  ---  -------------------------------------------------------------
// operand   in   mode, a_real, a_imag, b_real, b_imag, scale_factor
// result    out  res_real, res_imag, overflow
//
// One word is accepted per cycle while no result is stalled; each result passes
// through stage 0, stage 1, stage 2, the square root stages and the output
// register, which presents it. The depth is set by the square root, which resolves
// one root bit per pipeline stage.
// Reset (rst_n, asynchronous) clears only the valid bits of the stages.
// A stalled result freezes the whole pipeline and holds off new operand words,
// so nothing is lost or repeated.
module complex_alu
    import cpx_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    cpx_in_if.sink    operand,
    cpx_out_if.source result
);
    localparam int PW = 2 * DATA_WIDTH;
    localparam int WW = PW + 2;

    localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Finished result of the non-magnitude modes, carried past the root.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] re;
        logic [DATA_WIDTH-1:0] im;
        logic                  ovf;
        logic                  mag;
    } lane_t;

    logic adv;

    logic                         s0_vld_reg;
    mode_t                        s0_mode_reg;
    logic signed [DATA_WIDTH-1:0] s0_ar_reg;
    logic signed [DATA_WIDTH-1:0] s0_ai_reg;
    logic signed [DATA_WIDTH-1:0] s0_br_reg;
    logic signed [DATA_WIDTH-1:0] s0_bi_reg;
    logic signed [DATA_WIDTH-1:0] s0_t_reg;

    logic signed [DATA_WIDTH-1:0] x0, x1, x2, x3, y0, y1, y2, y3;
    logic signed [DATA_WIDTH:0]   ar_x, ai_x, br_x, bi_x;
    logic signed [DATA_WIDTH:0]   addsub_re_next, addsub_im_next;

    logic                         s1_vld_reg;
    mode_t                        s1_mode_reg;
    logic signed [PW-1:0]         s1_p0_reg, s1_p1_reg, s1_p2_reg, s1_p3_reg;
    logic signed [DATA_WIDTH:0]   s1_addsub_re_reg, s1_addsub_im_reg;

    logic signed [PW-1:0]         sh0, sh1, sh2, sh3;
    logic signed [PW:0]           neg0, shn0;
    logic signed [WW-1:0]         re_w, im_w;
    logic                         re_fits, im_fits;
    logic                         mag_sel;
    lane_t                        s2_lane_next;
    logic [PW-1:0]                s2_rad_next;

    logic                         s2_vld_reg;
    lane_t                        s2_lane_reg;
    logic [PW-1:0]                s2_rad_reg;

    logic                         dl_vld_reg  [DATA_WIDTH];
    lane_t                        dl_lane_reg [DATA_WIDTH];
    logic [DATA_WIDTH-1:0]        root;

    logic                         out_vld_reg;
    logic [DATA_WIDTH-1:0]        out_re_reg;
    logic [DATA_WIDTH-1:0]        out_im_reg;
    logic                         out_ovf_reg;

    // The pipeline moves whenever the output register is empty or being taken.
    assign adv           = !out_vld_reg || result.ready;
    assign operand.ready = adv;

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < DATA_WIDTH; i++)
            begin
                dl_vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s0_vld_reg    <= operand.valid;
            s1_vld_reg    <= s0_vld_reg;
            s2_vld_reg    <= s1_vld_reg;
            dl_vld_reg[0] <= s2_vld_reg;
            for (int i = 1; i < DATA_WIDTH; i++)
            begin
                dl_vld_reg[i] <= dl_vld_reg[i-1];
            end
            out_vld_reg   <= dl_vld_reg[DATA_WIDTH-1];
        end
    end

    // Stage 0: capture the operand word.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_mode_reg <= mode_t'(operand.mode);
            s0_ar_reg   <= operand.a_real;
            s0_ai_reg   <= operand.a_imag;
            s0_br_reg   <= operand.b_real;
            s0_bi_reg   <= operand.b_imag;
            s0_t_reg    <= operand.scale_factor;
        end
    end

    // Stage 1: pick the multiplier operands for the mode.
    always_comb
    begin
        x0 = s0_ar_reg;
        y0 = s0_br_reg;
        x1 = s0_ai_reg;
        y1 = s0_bi_reg;
        x2 = s0_ar_reg;
        y2 = s0_bi_reg;
        x3 = s0_ai_reg;
        y3 = s0_br_reg;
        unique case (s0_mode_reg)
            MODE_SCALE_RE:
            begin
                x0 = s0_t_reg;
                y0 = s0_ar_reg;
                x1 = s0_t_reg;
                y1 = s0_ai_reg;
            end
            MODE_SCALE_IM:
            begin
                x0 = s0_t_reg;
                y0 = s0_ai_reg;
                x1 = s0_t_reg;
                y1 = s0_ar_reg;
            end
            MODE_MAG:
            begin
                y0 = s0_ar_reg;
                y1 = s0_ai_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Stage 1: exact sum or difference, one bit wider than the operands.
    always_comb
    begin
        ar_x = {s0_ar_reg[DATA_WIDTH-1], s0_ar_reg};
        ai_x = {s0_ai_reg[DATA_WIDTH-1], s0_ai_reg};
        br_x = {s0_br_reg[DATA_WIDTH-1], s0_br_reg};
        bi_x = {s0_bi_reg[DATA_WIDTH-1], s0_bi_reg};
        if (s0_mode_reg == MODE_SUB)
        begin
            addsub_re_next = ar_x - br_x;
            addsub_im_next = ai_x - bi_x;
        end
        else
        begin
            addsub_re_next = ar_x + br_x;
            addsub_im_next = ai_x + bi_x;
        end
    end

    // Stage 1 registers: four full-width signed products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mode_reg      <= s0_mode_reg;
            s1_p0_reg        <= PW'(x0) * PW'(y0);
            s1_p1_reg        <= PW'(x1) * PW'(y1);
            s1_p2_reg        <= PW'(x2) * PW'(y2);
            s1_p3_reg        <= PW'(x3) * PW'(y3);
            s1_addsub_re_reg <= addsub_re_next;
            s1_addsub_im_reg <= addsub_im_next;
        end
    end

    // Stage 2: scale the products back to the fixed-point format.
    // In scale-imaginary mode the product is negated before it is shifted.
    always_comb
    begin
        sh0  = s1_p0_reg >>> FRAC_BITS;
        sh1  = s1_p1_reg >>> FRAC_BITS;
        sh2  = s1_p2_reg >>> FRAC_BITS;
        sh3  = s1_p3_reg >>> FRAC_BITS;
        neg0 = -$signed({s1_p0_reg[PW-1], s1_p0_reg});
        shn0 = neg0 >>> FRAC_BITS;
    end

    // Stage 2: form the wide result parts for the mode.
    always_comb
    begin
        re_w    = '0;
        im_w    = '0;
        mag_sel = 1'b0;
        unique case (s1_mode_reg)
            MODE_ADD, MODE_SUB:
            begin
                re_w = {{(WW-DATA_WIDTH-1){s1_addsub_re_reg[DATA_WIDTH]}}, s1_addsub_re_reg};
                im_w = {{(WW-DATA_WIDTH-1){s1_addsub_im_reg[DATA_WIDTH]}}, s1_addsub_im_reg};
            end
            MODE_SCALE_RE:
            begin
                re_w = {{(WW-PW){sh0[PW-1]}}, sh0};
                im_w = {{(WW-PW){sh1[PW-1]}}, sh1};
            end
            MODE_SCALE_IM:
            begin
                re_w = {{(WW-PW-1){shn0[PW]}}, shn0};
                im_w = {{(WW-PW){sh1[PW-1]}}, sh1};
            end
            MODE_MUL:
            begin
                re_w = {{(WW-PW){sh0[PW-1]}}, sh0} - {{(WW-PW){sh1[PW-1]}}, sh1};
                im_w = {{(WW-PW){sh2[PW-1]}}, sh2} + {{(WW-PW){sh3[PW-1]}}, sh3};
            end
            MODE_MAG:
            begin
                mag_sel = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Stage 2: clamp each part to the data range; the squares sum for the root.
    always_comb
    begin
        re_fits = (re_w[WW-1:DATA_WIDTH-1] == {(WW-DATA_WIDTH+1){re_w[DATA_WIDTH-1]}});
        im_fits = (im_w[WW-1:DATA_WIDTH-1] == {(WW-DATA_WIDTH+1){im_w[DATA_WIDTH-1]}});
        s2_lane_next.re  = re_fits ? re_w[DATA_WIDTH-1:0] : (re_w[WW-1] ? SAT_MIN : SAT_MAX);
        s2_lane_next.im  = im_fits ? im_w[DATA_WIDTH-1:0] : (im_w[WW-1] ? SAT_MIN : SAT_MAX);
        s2_lane_next.ovf = !re_fits || !im_fits;
        s2_lane_next.mag = mag_sel;
        // Both squares are non-negative and their sum stays below 2**PW.
        s2_rad_next      = $unsigned(s1_p0_reg) + $unsigned(s1_p1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_lane_reg <= s2_lane_next;
            s2_rad_reg  <= s2_rad_next;
        end
    end

    // Square root stages, with the other results delayed alongside.
    cpx_isqrt #(
        .ROOT_WIDTH (DATA_WIDTH)
    ) u_isqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (s2_rad_reg),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dl_lane_reg[0] <= s2_lane_reg;
            for (int i = 1; i < DATA_WIDTH; i++)
            begin
                dl_lane_reg[i] <= dl_lane_reg[i-1];
            end
        end
    end

    // Output register: a magnitude above the largest positive value is clamped.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dl_lane_reg[DATA_WIDTH-1].mag)
            begin
                out_re_reg  <= root[DATA_WIDTH-1] ? SAT_MAX : root;
                out_im_reg  <= '0;
                out_ovf_reg <= root[DATA_WIDTH-1];
            end
            else
            begin
                out_re_reg  <= dl_lane_reg[DATA_WIDTH-1].re;
                out_im_reg  <= dl_lane_reg[DATA_WIDTH-1].im;
                out_ovf_reg <= dl_lane_reg[DATA_WIDTH-1].ovf;
            end
        end
    end

    assign result.valid    = out_vld_reg;
    assign result.res_real = out_re_reg;
    assign result.res_imag = out_im_reg;
    assign result.overflow = out_ovf_reg;

endmodule

[tb/sv/complex_alu_tb.sv]
`timescale 1ns / 1ps

module complex_alu_tb;
    import cpx_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int PIPE_DEPTH = DW + 4;
    localparam int RANDOM_WORDS = 1650;
    localparam int MAX_GAP = 6;

    // Mode codes that the package leaves without an operation.
    localparam logic [MODE_WIDTH-1:0] MODE_UNUSED_A = MODE_WIDTH'(6);
    localparam logic [MODE_WIDTH-1:0] MODE_UNUSED_B = MODE_WIDTH'(7);

    localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] Q_ONE = 1 << FB;

    typedef logic signed [127:0] acc_t;

    typedef struct packed {
        logic [MODE_WIDTH-1:0] mode;
        logic signed [DW-1:0]  a_real;
        logic signed [DW-1:0]  a_imag;
        logic signed [DW-1:0]  b_real;
        logic signed [DW-1:0]  b_imag;
        logic signed [DW-1:0]  scale_factor;
    } operand_word_t;

    typedef struct packed {
        logic signed [DW-1:0] res_real;
        logic signed [DW-1:0] res_imag;
        logic                 overflow;
    } result_word_t;

    // Predicts each complex operation and checks the results in order.
    class alu_scoreboard;
        result_word_t pending_results[$];
        int mismatches;
        int results_seen;

        function new();
            mismatches = 0;
            results_seen = 0;
        endfunction

        // Full product, then an arithmetic shift that rounds toward minus infinity.
        function acc_t scaled_product(logic signed [DW-1:0] x, logic signed [DW-1:0] y);
            acc_t p;
            p = acc_t'(x) * acc_t'(y);
            return p >>> FB;
        endfunction

        function bit fits(acc_t v);
            return (v <= acc_t'(VAL_MAX)) && (v >= acc_t'(VAL_MIN));
        endfunction

        function logic signed [DW-1:0] clamp(acc_t v);
            if (v > acc_t'(VAL_MAX))
                return VAL_MAX;
            if (v < acc_t'(VAL_MIN))
                return VAL_MIN;
            return v[DW-1:0];
        endfunction

        // Bitwise integer square root, rounded down.
        function logic [63:0] floor_sqrt(logic [127:0] n);
            logic [63:0] root;
            logic [63:0] trial;
            root = '0;
            for (int b = 63; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if ({64'd0, trial} * {64'd0, trial} <= n)
                    root = trial;
            end
            return root;
        endfunction

        function result_word_t complex_op_result(operand_word_t w);
            acc_t re;
            acc_t im;
            logic [127:0] sum_sq;
            result_word_t r;
            re = '0;
            im = '0;
            case (w.mode)
                MODE_ADD:
                begin
                    re = acc_t'(w.a_real) + acc_t'(w.b_real);
                    im = acc_t'(w.a_imag) + acc_t'(w.b_imag);
                end
                MODE_SUB:
                begin
                    re = acc_t'(w.a_real) - acc_t'(w.b_real);
                    im = acc_t'(w.a_imag) - acc_t'(w.b_imag);
                end
                MODE_SCALE_RE:
                begin
                    re = scaled_product(w.scale_factor, w.a_real);
                    im = scaled_product(w.scale_factor, w.a_imag);
                end
                MODE_SCALE_IM:
                begin
                    // The product is negated before the shift, not after.
                    re = (-(acc_t'(w.scale_factor) * acc_t'(w.a_imag))) >>> FB;
                    im = scaled_product(w.scale_factor, w.a_real);
                end
                MODE_MUL:
                begin
                    re = scaled_product(w.a_real, w.b_real)
                         - scaled_product(w.a_imag, w.b_imag);
                    im = scaled_product(w.a_real, w.b_imag)
                         + scaled_product(w.a_imag, w.b_real);
                end
                MODE_MAG:
                begin
                    sum_sq = acc_t'(w.a_real) * acc_t'(w.a_real)
                             + acc_t'(w.a_imag) * acc_t'(w.a_imag);
                    re[63:0] = floor_sqrt(sum_sq);
                end
                default:
                begin
                    // Unused modes give zero with no overflow.
                end
            endcase
            r.res_real = clamp(re);
            r.res_imag = clamp(im);
            r.overflow = !(fits(re) && fits(im));
            return r;
        endfunction

        function void note_operand(operand_word_t w);
            pending_results.push_back(complex_op_result(w));
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(result_word_t got);
            result_word_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result word %0d arrived with none pending",
                                          results_seen));
                return;
            end
            want = pending_results.pop_front();
            if (got.res_real !== want.res_real)
                report_mismatch($sformatf("word %0d res_real %h, predicted %h",
                                          results_seen, got.res_real, want.res_real));
            if (got.res_imag !== want.res_imag)
                report_mismatch($sformatf("word %0d res_imag %h, predicted %h",
                                          results_seen, got.res_imag, want.res_imag));
            if (got.overflow !== want.overflow)
                report_mismatch($sformatf("word %0d overflow %b, predicted %b",
                                          results_seen, got.overflow, want.overflow));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit steady;
    alu_scoreboard board;
    operand_word_t seen_operand;
    result_word_t seen_result;

    cpx_in_if #(.DATA_WIDTH(DW)) operand_ch ();
    cpx_out_if #(.DATA_WIDTH(DW)) result_ch ();

    complex_alu #(
        .DATA_WIDTH(DW),
        .FRAC_BITS(FB)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .operand(operand_ch),
        .result(result_ch)
    );

    // Clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Sample both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (operand_ch.valid && operand_ch.ready)
            begin
                seen_operand.mode = operand_ch.mode;
                seen_operand.a_real = operand_ch.a_real;
                seen_operand.a_imag = operand_ch.a_imag;
                seen_operand.b_real = operand_ch.b_real;
                seen_operand.b_imag = operand_ch.b_imag;
                seen_operand.scale_factor = operand_ch.scale_factor;
                board.note_operand(seen_operand);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                seen_result.res_real = result_ch.res_real;
                seen_result.res_imag = result_ch.res_imag;
                seen_result.overflow = result_ch.overflow;
                board.check_result(seen_result);
            end
        end
    end

    // Result side: a random stall before each word, none while steady is set.
    initial
    begin
        int unsigned stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            @(posedge clk);
            while (result_ch.valid !== 1'b1)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Present one operand word after a random gap and hold it until taken.
    task send_word(operand_word_t w);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            operand_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operand_ch.mode = w.mode;
        operand_ch.a_real = w.a_real;
        operand_ch.a_imag = w.a_imag;
        operand_ch.b_real = w.b_real;
        operand_ch.b_imag = w.b_imag;
        operand_ch.scale_factor = w.scale_factor;
        operand_ch.valid = 1'b1;
        @(posedge clk);
        while (operand_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    task send_op(logic [MODE_WIDTH-1:0] mode, logic signed [DW-1:0] ar,
                 logic signed [DW-1:0] ai, logic signed [DW-1:0] br,
                 logic signed [DW-1:0] bi, logic signed [DW-1:0] t);
        operand_word_t w;
        w.mode = mode;
        w.a_real = ar;
        w.a_imag = ai;
        w.b_real = br;
        w.b_imag = bi;
        w.scale_factor = t;
        send_word(w);
    endtask

    // Operand values: extremes, unity, full-range noise and values near zero.
    function automatic logic signed [DW-1:0] random_operand();
        int unsigned pick;
        logic [63:0] raw;
        int near_zero;
        pick = $urandom_range(0, 15);
        raw = {$urandom, $urandom};
        near_zero = int'($urandom_range(0, 8 << FB)) - (4 << FB);
        case (pick)
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return Q_ONE;
            4: return -Q_ONE;
            5, 6, 7, 8, 9: return raw[DW-1:0];
            default: return near_zero;
        endcase
    endfunction

    function automatic operand_word_t random_word();
        operand_word_t w;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 18)
        begin
            case (pick % 6)
                0: w.mode = MODE_ADD;
                1: w.mode = MODE_SUB;
                2: w.mode = MODE_SCALE_RE;
                3: w.mode = MODE_SCALE_IM;
                4: w.mode = MODE_MUL;
                default: w.mode = MODE_MAG;
            endcase
        end
        else
            w.mode = pick[0] ? MODE_UNUSED_B : MODE_UNUSED_A;
        w.a_real = random_operand();
        w.a_imag = random_operand();
        w.b_real = random_operand();
        w.b_imag = random_operand();
        w.scale_factor = random_operand();
        return w;
    endfunction

    // Reset, directed words, random words, then drain.
    initial
    begin
        board = new();
        rst_n = 1'b0;
        steady = 1'b0;
        operand_ch.valid = 1'b0;
        operand_ch.mode = MODE_ADD;
        operand_ch.a_real = '0;
        operand_ch.a_imag = '0;
        operand_ch.b_real = '0;
        operand_ch.b_imag = '0;
        operand_ch.scale_factor = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Add and subtract: saturation at both ends, and exact cases.
        send_op(MODE_ADD, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, '0);
        send_op(MODE_ADD, VAL_MAX, -Q_ONE, VAL_MIN, Q_ONE, VAL_MAX);
        send_op(MODE_SUB, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, '0);
        send_op(MODE_SUB, 3 * Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, VAL_MIN);

        // Real scaling: unity, a saturating negation, rounding toward minus infinity.
        send_op(MODE_SCALE_RE, VAL_MIN, VAL_MAX, '0, '0, Q_ONE);
        send_op(MODE_SCALE_RE, VAL_MIN, 1, '0, '0, -Q_ONE);
        send_op(MODE_SCALE_RE, -1, 1, VAL_MAX, VAL_MIN, 1);

        // Imaginary scaling: the negation comes before the shift.
        send_op(MODE_SCALE_IM, '0, 1, '0, '0, 1);
        send_op(MODE_SCALE_IM, VAL_MIN, VAL_MIN, '0, '0, VAL_MIN);
        send_op(MODE_SCALE_IM, 2 * Q_ONE, 3 * Q_ONE, '0, '0, -Q_ONE);

        // Multiply: extremes, a conjugate product, per-product rounding.
        send_op(MODE_MUL, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, '0);
        send_op(MODE_MUL, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MAX, '0);
        send_op(MODE_MUL, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, '0);
        send_op(MODE_MUL, -1, 1, 1, 1, '0);

        // Magnitude: exact root, clamping above the range, zero, tiny values.
        send_op(MODE_MAG, 3 * Q_ONE, 4 * Q_ONE, VAL_MAX, VAL_MIN, VAL_MAX);
        send_op(MODE_MAG, VAL_MIN, VAL_MIN, '0, '0, '0);
        send_op(MODE_MAG, VAL_MAX, '0, '0, '0, '0);
        send_op(MODE_MAG, VAL_MIN, '0, '0, '0, '0);
        send_op(MODE_MAG, '0, '0, Q_ONE, Q_ONE, Q_ONE);
        send_op(MODE_MAG, -1, -1, '0, '0, '0);

        // Unused mode codes return zero.
        send_op(MODE_UNUSED_A, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX);
        send_op(MODE_UNUSED_B, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN);

        // Random words; every fourth stretch runs with no idling on either side.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            steady = ((i / 100) % 4) == 3;
            send_word(random_word());
        end
        steady = 1'b0;
        operand_ch.valid = 1'b0;

        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4 * MAX_GAP) @(posedge clk);

        if (board.mismatches == 0)
            $display("** complex_alu: PASSED **");
        else
            $display("** complex_alu: FAILED **");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5000000;
        $display("Timeout: results still pending");
        $display("** complex_alu: FAILED **");
        $finish;
    end

endmodule
